/* design/ucb1_pkg.sv */
// shared types and constants for the ucb1 child selection block
package ucb1_pkg;

	localparam int MAX_CHILDREN = 64;
	localparam int VISIT_BITS   = 32;
	localparam int FRAC_BITS    = 24;
	localparam int WINS_BITS    = VISIT_BITS + 1;
	localparam int SCORE_BITS   = FRAC_BITS + 4;
	localparam int IDX_BITS     = $clog2(MAX_CHILDREN);
	localparam int POS_BITS     = $clog2(MAX_CHILDREN + 1);
	localparam int EXP_BITS     = $clog2(VISIT_BITS);
	localparam int MANT_FRAC    = 30;
	localparam int MANT_BITS    = MANT_FRAC + 1;
	localparam int LOG_BITS     = EXP_BITS + FRAC_BITS;
	localparam int TL_BITS      = 30;
	localparam int RAD_BITS     = TL_BITS + FRAC_BITS;
	localparam int ROOT_BITS    = RAD_BITS / 2;
	localparam int RATE_BITS    = FRAC_BITS + 1;
	localparam int CNT_BITS     = 5;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [SCORE_BITS-1:0] MAX_CODE = {SCORE_BITS{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_NORM, ST_SQ_MUL, ST_SQ_FIX, ST_LN_MUL, ST_DIVY_LOAD,
		ST_DIV_Y, ST_RATE_LOAD, ST_DIV_R, ST_SQRT_LOAD, ST_SQRT, ST_SCORE, ST_UPDATE
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_LOAD, OP_NORM, OP_SQ_MUL, OP_SQ_FIX, OP_LN_MUL, OP_DIVY_LOAD,
		OP_DIV_STEP, OP_RATE_LOAD, OP_SQRT_LOAD, OP_SQRT_STEP, OP_SCORE, OP_UPDATE
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic v_zero;
		logic n_zero;
		logic norm_top;
		logic w_sat;
		logic last;
	} dp_status_t;

endpackage

/* design/ucb1_ctrl.sv */
// sequencer for the ucb1 scoring steps and the handshakes
module ucb1_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  ucb1_pkg::dp_status_t status,
	output ucb1_pkg::dp_cmd_t    cmd,
	output ucb1_pkg::state_t     state
);

	ucb1_pkg::state_t state_q, state_d;
	logic [ucb1_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ucb1_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd.op      = ucb1_pkg::OP_NOP;
		in_stall    = 1'b1;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			ucb1_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = ucb1_pkg::OP_LOAD;
					state_d = ucb1_pkg::ST_CHECK;
				end
			end
			ucb1_pkg::ST_CHECK: begin
				cnt_d = '0;
				if (status.v_zero)
					state_d = ucb1_pkg::ST_UPDATE;
				else if (status.n_zero)
					state_d = ucb1_pkg::ST_LN_MUL;
				else
					state_d = ucb1_pkg::ST_NORM;
			end
			ucb1_pkg::ST_NORM: begin
				cmd.op = ucb1_pkg::OP_NORM;
				if (status.norm_top)
					state_d = ucb1_pkg::ST_SQ_MUL;
			end
			ucb1_pkg::ST_SQ_MUL: begin
				cmd.op  = ucb1_pkg::OP_SQ_MUL;
				state_d = ucb1_pkg::ST_SQ_FIX;
			end
			ucb1_pkg::ST_SQ_FIX: begin
				cmd.op = ucb1_pkg::OP_SQ_FIX;
				if (cnt_q == ucb1_pkg::CNT_BITS'(ucb1_pkg::FRAC_BITS - 1)) begin
					cnt_d   = '0;
					state_d = ucb1_pkg::ST_LN_MUL;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = ucb1_pkg::ST_SQ_MUL;
				end
			end
			ucb1_pkg::ST_LN_MUL: begin
				cmd.op  = ucb1_pkg::OP_LN_MUL;
				state_d = ucb1_pkg::ST_DIVY_LOAD;
			end
			ucb1_pkg::ST_DIVY_LOAD: begin
				cmd.op  = ucb1_pkg::OP_DIVY_LOAD;
				cnt_d   = '0;
				state_d = ucb1_pkg::ST_DIV_Y;
			end
			ucb1_pkg::ST_DIV_Y: begin
				cmd.op = ucb1_pkg::OP_DIV_STEP;
				if (cnt_q == ucb1_pkg::CNT_BITS'(ucb1_pkg::TL_BITS - 1)) begin
					cnt_d   = '0;
					state_d = ucb1_pkg::ST_RATE_LOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ucb1_pkg::ST_RATE_LOAD: begin
				cmd.op  = ucb1_pkg::OP_RATE_LOAD;
				cnt_d   = '0;
				state_d = status.w_sat ? ucb1_pkg::ST_SQRT_LOAD : ucb1_pkg::ST_DIV_R;
			end
			ucb1_pkg::ST_DIV_R: begin
				cmd.op = ucb1_pkg::OP_DIV_STEP;
				if (cnt_q == ucb1_pkg::CNT_BITS'(ucb1_pkg::FRAC_BITS - 1)) begin
					cnt_d   = '0;
					state_d = ucb1_pkg::ST_SQRT_LOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ucb1_pkg::ST_SQRT_LOAD: begin
				cmd.op  = ucb1_pkg::OP_SQRT_LOAD;
				cnt_d   = '0;
				state_d = ucb1_pkg::ST_SQRT;
			end
			ucb1_pkg::ST_SQRT: begin
				cmd.op = ucb1_pkg::OP_SQRT_STEP;
				if (cnt_q == ucb1_pkg::CNT_BITS'(ucb1_pkg::ROOT_BITS - 1)) begin
					cnt_d   = '0;
					state_d = ucb1_pkg::ST_SCORE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ucb1_pkg::ST_SCORE: begin
				cmd.op  = ucb1_pkg::OP_SCORE;
				state_d = ucb1_pkg::ST_UPDATE;
			end
			ucb1_pkg::ST_UPDATE: begin
				// a closing child holds while the previous result beat is still stalled
				if (!(status.last && out_valid_q && out_stall)) begin
					cmd.op  = ucb1_pkg::OP_UPDATE;
					state_d = ucb1_pkg::ST_IDLE;
					if (status.last)
						out_valid_d = 1'b1;
				end
			end
			default: state_d = ucb1_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
	assign state     = state_q;

endmodule

/* design/ucb1_dp.sv */
// datapath: log2, shared multiplier, shared divider, square root, best tracking
module ucb1_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  ucb1_pkg::dp_cmd_t                       cmd,
	output ucb1_pkg::dp_status_t                    status,
	input  logic [ucb1_pkg::VISIT_BITS-1:0]         parent_visits,
	input  logic [ucb1_pkg::VISIT_BITS-1:0]         child_visits,
	input  logic [ucb1_pkg::WINS_BITS-1:0]          child_wins_half,
	input  logic                                    same_side,
	input  logic                                    last_child,
	output logic [ucb1_pkg::IDX_BITS-1:0]           selected_index,
	output logic [ucb1_pkg::SCORE_BITS-1:0]         best_score
);

	localparam int PROD_BITS = 64;
	localparam int DEN_BITS  = ucb1_pkg::WINS_BITS;

	logic [ucb1_pkg::VISIT_BITS-1:0] x_q, v_q;
	logic [ucb1_pkg::WINS_BITS-1:0]  w_q;
	logic                            same_q, last_q, n_zero_q;
	logic [ucb1_pkg::EXP_BITS-1:0]   e_q;
	logic [ucb1_pkg::MANT_BITS-1:0]  m_q;
	logic [ucb1_pkg::FRAC_BITS-1:0]  frac_q;
	logic [PROD_BITS-1:0]            prod_q;
	logic [DEN_BITS-1:0]             r_q, d_q;
	logic [ucb1_pkg::TL_BITS-1:0]    dd_q, q_q, y_q;
	logic [ucb1_pkg::RATE_BITS-1:0]  rate_q;
	logic [ucb1_pkg::RAD_BITS-1:0]   rad_q;
	logic [ucb1_pkg::ROOT_BITS-1:0]  root_q;
	logic [ucb1_pkg::ROOT_BITS+1:0]  rem_q;
	logic [ucb1_pkg::SCORE_BITS-1:0] score_q, best_q, out_score_q;
	logic [ucb1_pkg::IDX_BITS-1:0]   best_pos_q, out_idx_q;
	logic [ucb1_pkg::POS_BITS-1:0]   pos_q;
	logic                            have_q;

	logic [31:0]                     mul_a, mul_b;
	logic [DEN_BITS-1:0]             den;
	logic                            w_sat;
	logic [31:0]                     sq;
	logic [DEN_BITS:0]               rr;
	logic [ucb1_pkg::ROOT_BITS+3:0]  remsh;
	logic [ucb1_pkg::ROOT_BITS+1:0]  trial;
	logic [ucb1_pkg::SCORE_BITS:0]   sum;
	logic                            take;

	assign den   = {v_q, 1'b0};
	assign w_sat = (w_q >= den);
	assign sq    = prod_q[ucb1_pkg::MANT_FRAC +: 32];
	assign rr    = {r_q, dd_q[ucb1_pkg::TL_BITS-1]};
	assign remsh = {rem_q, rad_q[ucb1_pkg::RAD_BITS-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign sum   = (ucb1_pkg::SCORE_BITS+1)'(rate_q) + (ucb1_pkg::SCORE_BITS+1)'(root_q);
	assign take  = (pos_q < ucb1_pkg::POS_BITS'(ucb1_pkg::MAX_CHILDREN))
	               && (!have_q || (score_q > best_q));

	// one shared multiplier: mantissa squaring or log scaling
	always_comb begin
		if (cmd.op == ucb1_pkg::OP_LN_MUL) begin
			mul_a = 32'({e_q, frac_q});
			mul_b = ucb1_pkg::LN2_Q32;
		end else begin
			mul_a = 32'(m_q);
			mul_b = 32'(m_q);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ucb1_pkg::OP_LOAD: begin
				x_q      <= parent_visits;
				v_q      <= child_visits;
				w_q      <= child_wins_half;
				same_q   <= same_side;
				last_q   <= last_child;
				n_zero_q <= (parent_visits == '0);
				e_q      <= (parent_visits == '0) ? '0 : {ucb1_pkg::EXP_BITS{1'b1}};
				frac_q   <= '0;
				score_q  <= ucb1_pkg::MAX_CODE;
			end
			ucb1_pkg::OP_NORM: begin
				if (x_q[ucb1_pkg::VISIT_BITS-1]) begin
					m_q <= x_q[ucb1_pkg::VISIT_BITS-1:1];
				end else begin
					x_q <= {x_q[ucb1_pkg::VISIT_BITS-2:0], 1'b0};
					e_q <= e_q - 1'b1;
				end
			end
			ucb1_pkg::OP_SQ_MUL, ucb1_pkg::OP_LN_MUL: begin
				prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
			end
			ucb1_pkg::OP_SQ_FIX: begin
				frac_q <= {frac_q[ucb1_pkg::FRAC_BITS-2:0], sq[31]};
				m_q    <= sq[31] ? sq[31:1] : sq[30:0];
			end
			ucb1_pkg::OP_DIVY_LOAD: begin
				r_q  <= '0;
				d_q  <= DEN_BITS'(v_q);
				dd_q <= prod_q[31 +: ucb1_pkg::TL_BITS];
				q_q  <= '0;
			end
			ucb1_pkg::OP_DIV_STEP: begin
				if (rr >= (DEN_BITS+1)'(d_q)) begin
					r_q <= DEN_BITS'(rr - (DEN_BITS+1)'(d_q));
					q_q <= {q_q[ucb1_pkg::TL_BITS-2:0], 1'b1};
				end else begin
					r_q <= rr[DEN_BITS-1:0];
					q_q <= {q_q[ucb1_pkg::TL_BITS-2:0], 1'b0};
				end
				dd_q <= {dd_q[ucb1_pkg::TL_BITS-2:0], 1'b0};
			end
			ucb1_pkg::OP_RATE_LOAD: begin
				y_q  <= q_q;
				r_q  <= same_q ? w_q : den - w_q;
				d_q  <= den;
				dd_q <= '0;
				q_q  <= '0;
				if (w_sat)
					rate_q <= same_q ? {1'b1, {ucb1_pkg::FRAC_BITS{1'b0}}} : '0;
			end
			ucb1_pkg::OP_SQRT_LOAD: begin
				if (!w_sat)
					rate_q <= ucb1_pkg::RATE_BITS'(q_q[ucb1_pkg::FRAC_BITS-1:0]);
				rad_q  <= {y_q, {ucb1_pkg::FRAC_BITS{1'b0}}};
				root_q <= '0;
				rem_q  <= '0;
			end
			ucb1_pkg::OP_SQRT_STEP: begin
				if (remsh >= (ucb1_pkg::ROOT_BITS+4)'(trial)) begin
					rem_q  <= (ucb1_pkg::ROOT_BITS+2)'(remsh - (ucb1_pkg::ROOT_BITS+4)'(trial));
					root_q <= {root_q[ucb1_pkg::ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_q  <= remsh[ucb1_pkg::ROOT_BITS+1:0];
					root_q <= {root_q[ucb1_pkg::ROOT_BITS-2:0], 1'b0};
				end
				rad_q <= {rad_q[ucb1_pkg::RAD_BITS-3:0], 2'b00};
			end
			ucb1_pkg::OP_SCORE: begin
				if (sum >= (ucb1_pkg::SCORE_BITS+1)'(ucb1_pkg::MAX_CODE))
					score_q <= ucb1_pkg::MAX_CODE - 1'b1;
				else
					score_q <= sum[ucb1_pkg::SCORE_BITS-1:0];
			end
			ucb1_pkg::OP_UPDATE: begin
				if (last_q) begin
					out_idx_q   <= take ? pos_q[ucb1_pkg::IDX_BITS-1:0] : best_pos_q;
					out_score_q <= take ? score_q : best_q;
				end
			end
			default: begin
			end
		endcase
	end

	// running best and position, cleared at the close of a selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_pos_q <= '0;
			pos_q      <= '0;
			have_q     <= 1'b0;
		end else if (cmd.op == ucb1_pkg::OP_UPDATE) begin
			if (last_q) begin
				best_q     <= '0;
				best_pos_q <= '0;
				pos_q      <= '0;
				have_q     <= 1'b0;
			end else if (pos_q < ucb1_pkg::POS_BITS'(ucb1_pkg::MAX_CHILDREN)) begin
				if (take) begin
					best_q     <= score_q;
					best_pos_q <= pos_q[ucb1_pkg::IDX_BITS-1:0];
					have_q     <= 1'b1;
				end
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	assign status.v_zero   = (v_q == '0);
	assign status.n_zero   = n_zero_q;
	assign status.norm_top = x_q[ucb1_pkg::VISIT_BITS-1];
	assign status.w_sat    = w_sat;
	assign status.last     = last_q;

	assign selected_index = out_idx_q;
	assign best_score     = out_score_q;

endmodule

/* design/ucb1_child_select_top.sv */
// top level of the ucb1 child selection block
//
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_stall   | parent_visits, child_visits, child_wins_half, same_side, last_child
//  out     | out | out_valid/out_stall | selected_index, best_score
//
// one child beat at a time; a new beat is taken only when the last one is done
// unvisited child: check, update, idle
// visited child: a leading-one search, 24 square-and-fix pairs, 30 + 24 divider
// steps and 27 square root steps; the rate division is skipped when wins reach
// twice the visits, the search and squaring when the parent count is zero
// arst_n clears the sequencer, the running best and the result valid; a stalled
// result beat holds and only the update of the next closing child waits on it
module ucb1_child_select_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ucb1_pkg::VISIT_BITS-1:0]     parent_visits,
	input  logic [ucb1_pkg::VISIT_BITS-1:0]     child_visits,
	input  logic [ucb1_pkg::WINS_BITS-1:0]      child_wins_half,
	input  logic                                same_side,
	input  logic                                last_child,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ucb1_pkg::IDX_BITS-1:0]       selected_index,
	output logic [ucb1_pkg::SCORE_BITS-1:0]     best_score
);

	// command and status between sequencer and datapath
	ucb1_pkg::dp_cmd_t    cmd;
	ucb1_pkg::dp_status_t status;
	ucb1_pkg::state_t     state;

	ucb1_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.state     (state)
	);

	ucb1_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.parent_visits   (parent_visits),
		.child_visits    (child_visits),
		.child_wins_half (child_wins_half),
		.same_side       (same_side),
		.last_child      (last_child),
		.selected_index  (selected_index),
		.best_score      (best_score)
	);

`ifndef SYNTHESIS
	// an accepted beat makes the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while scoring");

	// a new result beat only follows the update of a closing child
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state) == ucb1_pkg::ST_UPDATE && $past(status.last)))
		else $error("result without a closing child");

	// the update never overwrites a result beat that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == ucb1_pkg::OP_UPDATE && status.last) |-> !(out_valid && out_stall))
		else $error("pending result overwritten");
`endif

endmodule
